[hw/rtl/csr_pkg.sv]
// Shared types and constants for the circle span rasterizer.
package csr_pkg;

    // Field widths fixed by the item format
    localparam int CENTER_W   = 15;
    localparam int RADIUS_W   = 14;
    localparam int DECISION_W = 17;
    localparam int PHASE_W    = 3;

    // Default output coordinate width
    localparam int COORD_BITS_DEFAULT = 16;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Command class decoded from the kind field
    typedef enum logic [0:0] {
        CSR_OP_START   = 1'b0,
        CSR_OP_ADVANCE = 1'b1
    } csr_op_t;

    // One queued command beat
    typedef struct packed {
        csr_op_t                     op;
        logic signed [CENTER_W-1:0]  center_x;
        logic signed [CENTER_W-1:0]  center_y;
        logic        [RADIUS_W-1:0]  radius;
        logic                        fill_mode;
    } csr_cmd_t;

endpackage

[hw/rtl/csr_cmd_queue.sv]
// Front end: accepts command beats, classifies them and buffers them in a short queue.
module csr_cmd_queue
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 kind,
    input  logic signed [csr_pkg::CENTER_W-1:0]  center_x,
    input  logic signed [csr_pkg::CENTER_W-1:0]  center_y,
    input  logic        [csr_pkg::RADIUS_W-1:0]  radius,
    input  logic                                 fill_mode,
    output logic                                 cmd_valid,
    output csr_pkg::csr_cmd_t                    cmd,
    input  logic                                 pop
);

    csr_pkg::csr_cmd_t                   entry_reg [csr_pkg::QUEUE_DEPTH];
    logic [csr_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [csr_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [csr_pkg::QUEUE_CNT_W-1:0]     count_reg, count_next;
    csr_pkg::csr_cmd_t                   in_cmd;
    logic                                push;
    logic                                do_pop;

    // Classify the incoming beat
    always_comb
    begin
        in_cmd.op        = kind ? csr_pkg::CSR_OP_ADVANCE : csr_pkg::CSR_OP_START;
        in_cmd.center_x  = center_x;
        in_cmd.center_y  = center_y;
        in_cmd.radius    = radius;
        in_cmd.fill_mode = fill_mode;
    end

    assign busy      = (count_reg == csr_pkg::QUEUE_CNT_W'(csr_pkg::QUEUE_DEPTH));
    assign push      = start && !busy;
    assign cmd_valid = (count_reg != '0);
    assign do_pop    = pop && cmd_valid;
    assign cmd       = entry_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push   ? csr_pkg::QUEUE_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? csr_pkg::QUEUE_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        unique case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the command payload
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

[hw/rtl/csr_engine.sv]
// Back end: runs the three-way decision (Andres) circle walk and emits one span or point per advance.
module csr_engine
#(
    parameter int COORD_BITS = csr_pkg::COORD_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  csr_pkg::csr_cmd_t             cmd,
    output logic                          pop,
    output logic                          span_strobe,
    output logic signed [COORD_BITS-1:0]  span_x_start,
    output logic signed [COORD_BITS-1:0]  span_x_end,
    output logic signed [COORD_BITS-1:0]  span_y,
    output logic                          last_primitive
);

    localparam int CALC_W = (COORD_BITS > csr_pkg::CENTER_W + 2) ?
                            COORD_BITS : csr_pkg::CENTER_W + 2;
    localparam int DW     = csr_pkg::DECISION_W + 2;
    localparam int OW     = csr_pkg::RADIUS_W + 2;
    localparam logic signed [DW-1:0] ONE_D = 1;
    localparam logic signed [OW-1:0] ONE_O = 1;

    // Circle state
    logic signed [csr_pkg::CENTER_W-1:0]   cx_reg, cx_next;
    logic signed [csr_pkg::CENTER_W-1:0]   cy_reg, cy_next;
    logic        [csr_pkg::RADIUS_W-1:0]   rad_reg, rad_next;
    logic                                  fill_reg, fill_next;
    logic        [csr_pkg::RADIUS_W-1:0]   off_x_reg, off_x_next;
    logic        [csr_pkg::RADIUS_W-1:0]   off_y_reg, off_y_next;
    logic signed [csr_pkg::DECISION_W-1:0] decision_reg, decision_next;
    logic        [csr_pkg::PHASE_W-1:0]    phase_reg, phase_next;
    logic                                  active_reg, active_next;

    // Result registers
    logic                                  strobe_reg, strobe_next;
    logic                                  last_reg, last_next;
    logic signed [COORD_BITS-1:0]          xs_reg, xs_next;
    logic signed [COORD_BITS-1:0]          xe_reg, xe_next;
    logic signed [COORD_BITS-1:0]          yy_reg, yy_next;

    // Datapath nets
    logic        [csr_pkg::RADIUS_W-1:0]   a_sel, b_sel;
    logic                                  x_neg, y_neg;
    logic signed [CALC_W-1:0]              cx_w, cy_w, a_w, b_w;
    logic signed [CALC_W-1:0]              x_plus, x_minus, y_sum;
    logic signed [CALC_W-1:0]              xs_w, xe_w;
    logic        [csr_pkg::PHASE_W-1:0]    nph;
    logic                                  step_end;
    logic signed [DW-1:0]                  d_w, ox_d, oy_d, r_d, two_ox, two_r_oy, d_new;
    logic signed [OW-1:0]                  ox_w, oy_w, ox_n, oy_n;
    logic                                  done;

    assign pop = cmd_valid;

    // Pick the offset operands and signs for the current phase
    always_comb
    begin
        if (fill_reg)
        begin
            a_sel = (phase_reg[0] ^ phase_reg[1]) ? off_x_reg : off_y_reg;
            b_sel = (phase_reg[0] ^ phase_reg[1]) ? off_y_reg : off_x_reg;
            x_neg = 1'b1;
            y_neg = phase_reg[1];
            nph   = {1'b0, 2'(phase_reg[1:0] + 2'd1)};
        end
        else
        begin
            a_sel = phase_reg[0] ? off_y_reg : off_x_reg;
            b_sel = phase_reg[0] ? off_x_reg : off_y_reg;
            x_neg = phase_reg[1];
            y_neg = phase_reg[2];
            nph   = csr_pkg::PHASE_W'(phase_reg + 1'b1);
        end
        step_end = (nph == '0);
    end

    // Form the primitive coordinates
    always_comb
    begin
        cx_w    = CALC_W'(cx_reg);
        cy_w    = CALC_W'(cy_reg);
        a_w     = CALC_W'(a_sel);
        b_w     = CALC_W'(b_sel);
        x_plus  = cx_w + a_w;
        x_minus = cx_w - a_w;
        y_sum   = y_neg ? (cy_w - b_w) : (cy_w + b_w);
        xs_w    = x_neg ? x_minus : x_plus;
        xe_w    = fill_reg ? x_plus : xs_w;
    end

    // Three-way decision update at the end of a step
    always_comb
    begin
        d_w      = DW'(decision_reg);
        ox_d     = DW'(off_x_reg);
        oy_d     = DW'(off_y_reg);
        r_d      = DW'(rad_reg);
        two_ox   = ox_d + ox_d;
        two_r_oy = (r_d - oy_d) + (r_d - oy_d);
        ox_w     = OW'(off_x_reg);
        oy_w     = OW'(off_y_reg);
        priority if (d_w >= two_ox)
        begin
            d_new = d_w - two_ox - ONE_D;
            ox_n  = ox_w + ONE_O;
            oy_n  = oy_w;
        end
        else if (d_w < two_r_oy)
        begin
            d_new = d_w + oy_d + oy_d - ONE_D;
            ox_n  = ox_w;
            oy_n  = oy_w - ONE_O;
        end
        else
        begin
            d_new = d_w + (oy_d - ox_d - ONE_D) + (oy_d - ox_d - ONE_D);
            ox_n  = ox_w + ONE_O;
            oy_n  = oy_w - ONE_O;
        end
        done = (oy_n < ox_n);
    end

    // Next state for a popped command beat
    always_comb
    begin
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        rad_next      = rad_reg;
        fill_next     = fill_reg;
        off_x_next    = off_x_reg;
        off_y_next    = off_y_reg;
        decision_next = decision_reg;
        phase_next    = phase_reg;
        active_next   = active_reg;
        strobe_next   = 1'b0;
        last_next     = 1'b0;
        xs_next       = xs_reg;
        xe_next       = xe_reg;
        yy_next       = yy_reg;
        if (cmd_valid)
        begin
            unique case (cmd.op)
                csr_pkg::CSR_OP_START:
                begin
                    cx_next       = cmd.center_x;
                    cy_next       = cmd.center_y;
                    rad_next      = cmd.radius;
                    fill_next     = cmd.fill_mode;
                    off_x_next    = '0;
                    off_y_next    = cmd.radius;
                    decision_next = csr_pkg::DECISION_W'(
                                    csr_pkg::DECISION_W'(cmd.radius) - 1'b1);
                    phase_next    = '0;
                    active_next   = 1'b1;
                end
                csr_pkg::CSR_OP_ADVANCE:
                begin
                    if (active_reg)
                    begin
                        strobe_next = 1'b1;
                        xs_next     = xs_w[COORD_BITS-1:0];
                        xe_next     = xe_w[COORD_BITS-1:0];
                        yy_next     = y_sum[COORD_BITS-1:0];
                        phase_next  = nph;
                        if (step_end)
                        begin
                            off_x_next    = ox_n[csr_pkg::RADIUS_W-1:0];
                            off_y_next    = oy_n[csr_pkg::RADIUS_W-1:0];
                            decision_next = d_new[csr_pkg::DECISION_W-1:0];
                            last_next     = done;
                            active_next   = !done;
                        end
                    end
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            phase_reg  <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    // Payload state
    always_ff @(posedge clk)
    begin
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        rad_reg      <= rad_next;
        fill_reg     <= fill_next;
        off_x_reg    <= off_x_next;
        off_y_reg    <= off_y_next;
        decision_reg <= decision_next;
        xs_reg       <= xs_next;
        xe_reg       <= xe_next;
        yy_reg       <= yy_next;
    end

    assign span_strobe    = strobe_reg;
    assign span_x_start   = xs_reg;
    assign span_x_end     = xe_reg;
    assign span_y         = yy_reg;
    assign last_primitive = last_reg;

    // A result beat only follows an advance beat
    a_strobe_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(cmd_valid && (cmd.op == csr_pkg::CSR_OP_ADVANCE)))
        else $error("result beat without advance");

    // The final primitive leaves the walk idle
    a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |-> !active_reg)
        else $error("walk still active after last primitive");

    // Filled walk uses four phases only
    a_fill_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && fill_reg) |-> !phase_reg[2])
        else $error("fill phase out of range");

    // A running walk stays inside its octant
    a_octant: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (off_y_reg >= off_x_reg))
        else $error("offsets left the octant while active");

endmodule

[hw/rtl/circle_span_rasterizer_unit.sv]
// Top level of the circle span rasterizer: command queue front end and walk engine.
//
//  channel  | ports                                              | handshake
//  ---------+----------------------------------------------------+-------------------------
//  command  | kind, center_x, center_y, radius, fill_mode        | start high, busy low
//  result   | span_x_start, span_x_end, span_y, last_primitive   | span_strobe, one cycle
//
//  A command beat accepted at one edge is taken from the queue in the next cycle; for an advance
//  on an active walk, its result beat shows on the result ports in the cycle after that.
//  The engine drains one queued beat per cycle, so one advance yields one primitive
//  per cycle; the walk update in the engine is computed combinationally from its registers.
//  The engine pops every cycle, so the two-entry queue never fills and busy stays low.
//  Reset clears the queue and leaves the walk idle; the receiver cannot stall.
module circle_span_rasterizer_unit
#(
    parameter int COORD_BITS = csr_pkg::COORD_BITS_DEFAULT
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 kind,
    input  logic signed [csr_pkg::CENTER_W-1:0]  center_x,
    input  logic signed [csr_pkg::CENTER_W-1:0]  center_y,
    input  logic        [csr_pkg::RADIUS_W-1:0]  radius,
    input  logic                                 fill_mode,
    output logic                                 span_strobe,
    output logic signed [COORD_BITS-1:0]         span_x_start,
    output logic signed [COORD_BITS-1:0]         span_x_end,
    output logic signed [COORD_BITS-1:0]         span_y,
    output logic                                 last_primitive
);

    logic              cmd_valid;
    logic              cmd_pop;
    csr_pkg::csr_cmd_t cmd;

    // Accept and buffer command beats
    csr_cmd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .center_x  (center_x),
        .center_y  (center_y),
        .radius    (radius),
        .fill_mode (fill_mode),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .pop       (cmd_pop)
    );

    // Walk the circle
    csr_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .pop            (cmd_pop),
        .span_strobe    (span_strobe),
        .span_x_start   (span_x_start),
        .span_x_end     (span_x_end),
        .span_y         (span_y),
        .last_primitive (last_primitive)
    );

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the circle span rasterizer unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = csr_pkg::COORD_BITS_DEFAULT;
    localparam int ITEM_TARGET = 1550;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;

    localparam logic signed [csr_pkg::CENTER_W-1:0] XY_MIN = 15'sh4000;
    localparam logic signed [csr_pkg::CENTER_W-1:0] XY_MAX = 15'sh3FFF;
    localparam logic        [csr_pkg::RADIUS_W-1:0] R_MAX  = 14'h3FFF;

    // Track the walk of the circle and the primitives it must produce
    class span_tracker;
        typedef struct {
            logic [CW-1:0] xs;
            logic [CW-1:0] xe;
            logic [CW-1:0] y;
            logic          last;
        } span_t;

        span_t                                pending_spans[$];
        logic signed [csr_pkg::CENTER_W-1:0]  ctr_x, ctr_y;
        logic        [csr_pkg::RADIUS_W-1:0]  rad;
        logic                                 fill;
        logic        [csr_pkg::RADIUS_W-1:0]  step_x, step_y;
        logic        [csr_pkg::DECISION_W-1:0] dvar;
        logic        [csr_pkg::PHASE_W-1:0]   phase;
        bit                                   walking_q;
        int errors, points, spans, finished, dropped, ignored;

        function new();
            ctr_x = '0; ctr_y = '0; rad = '0; fill = 1'b0;
            step_x = '0; step_y = '0; dvar = '0; phase = '0;
            walking_q = 1'b0;
            errors = 0; points = 0; spans = 0;
            finished = 0; dropped = 0; ignored = 0;
        endfunction

        function bit walking();
            return walking_q;
        endfunction

        function int outstanding();
            return pending_spans.size();
        endfunction

        // Note an accepted command beat and predict its primitive
        function void take_command(csr_pkg::csr_op_t op,
                                   logic signed [csr_pkg::CENTER_W-1:0] px,
                                   logic signed [csr_pkg::CENTER_W-1:0] py,
                                   logic [csr_pkg::RADIUS_W-1:0] pr, logic pf);
            int cx, cy, ox, oy, r, d, xs, xe, yy;
            logic [csr_pkg::PHASE_W-1:0] nph;
            span_t s;
            if (op == csr_pkg::CSR_OP_START)
            begin
                if (walking_q)
                    dropped++;
                ctr_x = px; ctr_y = py; rad = pr; fill = pf;
                step_x = '0; step_y = pr;
                d = int'(pr) - 1;
                dvar = d[csr_pkg::DECISION_W-1:0];
                phase = '0;
                walking_q = 1'b1;
                return;
            end
            if (!walking_q)
            begin
                ignored++;
                return;
            end
            cx = ctr_x; cy = ctr_y; ox = step_x; oy = step_y; r = rad;
            s.last = 1'b0;

            // Pick the symmetric primitive for this phase
            if (fill)
            begin
                case (phase[1:0])
                    2'd0: begin xs = cx - oy; xe = cx + oy; yy = cy + ox; end
                    2'd1: begin xs = cx - ox; xe = cx + ox; yy = cy + oy; end
                    2'd2: begin xs = cx - ox; xe = cx + ox; yy = cy - oy; end
                    default: begin xs = cx - oy; xe = cx + oy; yy = cy - ox; end
                endcase
                nph = (phase[1:0] == 2'd3) ? '0 : {1'b0, phase[1:0]} + 3'd1;
                spans++;
            end
            else
            begin
                case (phase)
                    3'd0: begin xs = cx + ox; yy = cy + oy; end
                    3'd1: begin xs = cx + oy; yy = cy + ox; end
                    3'd2: begin xs = cx - ox; yy = cy + oy; end
                    3'd3: begin xs = cx - oy; yy = cy + ox; end
                    3'd4: begin xs = cx + ox; yy = cy - oy; end
                    3'd5: begin xs = cx + oy; yy = cy - ox; end
                    3'd6: begin xs = cx - ox; yy = cy - oy; end
                    default: begin xs = cx - oy; yy = cy - ox; end
                endcase
                xe = xs;
                nph = phase + 3'd1;
                points++;
            end

            // Advance the walk once the step's last primitive is out
            if (nph == '0)
            begin
                d = int'($signed(dvar));
                if (d >= 2 * ox)
                begin
                    d = d - (2 * ox + 1);
                    ox = ox + 1;
                end
                else if (d < 2 * (r - oy))
                begin
                    d = d + 2 * oy - 1;
                    oy = oy - 1;
                end
                else
                begin
                    d = d + 2 * (oy - ox - 1);
                    oy = oy - 1;
                    ox = ox + 1;
                end
                if (oy < ox)
                begin
                    s.last = 1'b1;
                    walking_q = 1'b0;
                    finished++;
                end
                step_x = ox[csr_pkg::RADIUS_W-1:0];
                step_y = oy[csr_pkg::RADIUS_W-1:0];
                dvar = d[csr_pkg::DECISION_W-1:0];
            end
            phase = nph;

            s.xs = xs[CW-1:0];
            s.xe = xe[CW-1:0];
            s.y  = yy[CW-1:0];
            pending_spans.push_back(s);
        endfunction

        // Compare one result beat against the oldest prediction
        function void check_span(logic [CW-1:0] xs, logic [CW-1:0] xe,
                                 logic [CW-1:0] y, logic last);
            span_t s;
            if (pending_spans.size() == 0)
            begin
                $error("unexpected span beat: x_start %0d x_end %0d y %0d last %0b",
                       $signed(xs), $signed(xe), $signed(y), last);
                errors++;
                return;
            end
            s = pending_spans.pop_front();
            if (xs !== s.xs)
            begin
                $error("span_x_start: expected %0d, got %0d", $signed(s.xs), $signed(xs));
                errors++;
            end
            if (xe !== s.xe)
            begin
                $error("span_x_end: expected %0d, got %0d", $signed(s.xe), $signed(xe));
                errors++;
            end
            if (y !== s.y)
            begin
                $error("span_y: expected %0d, got %0d", $signed(s.y), $signed(y));
                errors++;
            end
            if (last !== s.last)
            begin
                $error("last_primitive: expected %0b, got %0b", s.last, last);
                errors++;
            end
        endfunction

        function void close_out();
            if (pending_spans.size() != 0)
            begin
                $error("%0d predicted span beats never arrived", pending_spans.size());
                errors++;
            end
        endfunction
    endclass

    logic                                  clk = 1'b0;
    logic                                  rst_n;
    logic                                  start;
    logic                                  busy;
    logic                                  kind;
    logic signed [csr_pkg::CENTER_W-1:0]   center_x;
    logic signed [csr_pkg::CENTER_W-1:0]   center_y;
    logic        [csr_pkg::RADIUS_W-1:0]   radius;
    logic                                  fill_mode;
    logic                                  span_strobe;
    logic signed [CW-1:0]                  span_x_start;
    logic signed [CW-1:0]                  span_x_end;
    logic signed [CW-1:0]                  span_y;
    logic                                  last_primitive;

    span_tracker tracker = new();
    int          counted = 0;
    int          stall_cycles;
    bit          quiet = 1'b0;

    circle_span_rasterizer_unit #(.COORD_BITS(CW)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .center_x       (center_x),
        .center_y       (center_y),
        .radius         (radius),
        .fill_mode      (fill_mode),
        .span_strobe    (span_strobe),
        .span_x_start   (span_x_start),
        .span_x_end     (span_x_end),
        .span_y         (span_y),
        .last_primitive (last_primitive)
    );

    // Free-running clock
    always #10 clk = ~clk;

    // Check result beats and watch for a hang
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else
        begin
            if (span_strobe)
                tracker.check_span(span_x_start, span_x_end, span_y, last_primitive);
            if ((start && !busy) || span_strobe)
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("circle_span_rasterizer_unit regression: fail");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic signed [csr_pkg::CENTER_W-1:0] rand_coord();
        logic [31:0] v;
        v = $urandom();
        return v[csr_pkg::CENTER_W-1:0];
    endfunction

    function automatic logic [csr_pkg::RADIUS_W-1:0] rand_radius();
        logic [31:0] v;
        v = $urandom();
        return v[csr_pkg::RADIUS_W-1:0];
    endfunction

    // Drive one command beat from a falling edge and hold it until accepted
    task automatic send_beat(input csr_pkg::csr_op_t op,
                             input logic signed [csr_pkg::CENTER_W-1:0] px,
                             input logic signed [csr_pkg::CENTER_W-1:0] py,
                             input logic [csr_pkg::RADIUS_W-1:0] pr, input logic pf);
        kind      = op;
        center_x  = px;
        center_y  = py;
        radius    = pr;
        fill_mode = pf;
        start     = 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(negedge clk);
            @(posedge clk);
        end
        if (op == csr_pkg::CSR_OP_START || tracker.walking())
            counted++;
        tracker.take_command(op, px, py, pr, pf);
        @(negedge clk);
    endtask

    task automatic send_advance();
        send_beat(csr_pkg::CSR_OP_ADVANCE, rand_coord(), rand_coord(), rand_radius(),
                  1'($urandom_range(0, 1)));
    endtask

    // Drop start for a burst of idle cycles
    task automatic maybe_gap(input bit gappy);
        if (gappy && !quiet && $urandom_range(0, 3) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
    endtask

    // One circle: mostly walked to its end, sometimes cut short by the next start
    task automatic random_circle();
        int                           sel;
        int                           cap;
        int                           n;
        bit                           gappy;
        logic [csr_pkg::RADIUS_W-1:0] r;
        sel   = $urandom_range(0, 19);
        gappy = ($urandom_range(0, 2) != 0);
        cap   = -1;
        if (sel < 15)
            r = csr_pkg::RADIUS_W'($urandom_range(0, 12));
        else if (sel < 18)
            r = csr_pkg::RADIUS_W'($urandom_range(13, 60));
        else
            r = rand_radius();
        if (r > 60)
            cap = $urandom_range(0, 48);
        else if ($urandom_range(0, 7) == 0)
            cap = $urandom_range(0, 20);

        maybe_gap(gappy);
        send_beat(csr_pkg::CSR_OP_START, rand_coord(), rand_coord(), r,
                  1'($urandom_range(0, 1)));
        n = 0;
        while (tracker.walking() && (cap < 0 || n < cap) && counted < ITEM_TARGET)
        begin
            maybe_gap(gappy);
            send_advance();
            n++;
        end

        // Inject stray advances now and then
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) send_advance();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        kind      = csr_pkg::CSR_OP_START;
        center_x  = '0;
        center_y  = '0;
        radius    = '0;
        fill_mode = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: idle advance, zero radius both modes, extreme centers and radius
        send_beat(csr_pkg::CSR_OP_ADVANCE, XY_MAX, XY_MIN, R_MAX, 1'b1);
        send_beat(csr_pkg::CSR_OP_START, XY_MIN, XY_MAX, '0, 1'b0);
        repeat (8) send_advance();
        send_beat(csr_pkg::CSR_OP_START, XY_MAX, XY_MIN, '0, 1'b1);
        repeat (4) send_advance();
        send_advance();
        send_beat(csr_pkg::CSR_OP_START, XY_MAX, XY_MAX, R_MAX, 1'b0);
        repeat (4) send_advance();
        send_beat(csr_pkg::CSR_OP_START, XY_MIN, XY_MIN, R_MAX, 1'b1);
        repeat (4) send_advance();

        // Random circles; the tail runs without idle bursts
        while (counted < ITEM_TARGET)
        begin
            quiet = (counted > ITEM_TARGET * 85 / 100);
            random_circle();
        end
        start = 1'b0;

        // Drain the outstanding primitives
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        tracker.close_out();

        $display("covered %0d command beats: %0d points, %0d spans, %0d circles closed",
                 counted, tracker.points, tracker.spans, tracker.finished);
        $display("%0d circles cut short by a new start, %0d advances ignored while idle",
                 tracker.dropped, tracker.ignored);
        if (tracker.errors == 0)
            $display("circle_span_rasterizer_unit regression: pass");
        else
            $display("circle_span_rasterizer_unit regression: fail");
        $finish;
    end
endmodule

[circle_span_rasterizer_unit.f]
hw/rtl/csr_pkg.sv
hw/rtl/csr_cmd_queue.sv
hw/rtl/csr_engine.sv
hw/rtl/circle_span_rasterizer_unit.sv
tb/sv/tb_top.sv
